/* hdl/lcfr_pkg.sv */
// ----------------------------------------------------------------------------
// lcfr_pkg
// Shared types and constants of the line/circle frame store rasterizer.
// ----------------------------------------------------------------------------
package lcfr_pkg;

   localparam int COORD_W = 8;
   localparam int COLOR_W = 16;
   localparam int RAD_W   = 7;

   typedef enum logic [1:0] {
      OP_FILL   = 2'd0,
      OP_LINE   = 2'd1,
      OP_CIRCLE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_LINE_CHK,
      ST_HSPAN,
      ST_VSPAN,
      ST_BRES_END,
      ST_BRES,
      ST_CIRC_PT,
      ST_CIRC_STEP,
      ST_READ_ADDR,
      ST_READ_WAIT,
      ST_READ_DATA,
      ST_DONE
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic       load;       // capture request fields
      logic       fill_init;
      logic       fill_step;
      logic       span_init;
      logic       span_step;
      logic       bres_init;
      logic       bres_step;
      logic       circ_init;
      logic       circ_next;  // next of four symmetric points
      logic       circ_step;
      logic [1:0] wsel;       // 0 fill, 1 span/bres point, 2 bres end, 3 circle point
      logic       wr;
      logic       rd;
      logic       take_pixel;
      logic       set_reject;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      op_type op;
      logic   fill_last;
      logic   fill_empty;
      logic   ends_ok;
      logic   horiz;
      logic   vert;
      logic   span_last;
      logic   bres_done;   // current point equals far endpoint
      logic   bres_out;    // after a step, new point out of bounds
      logic   circ_ok;     // current symmetric point in bounds
      logic   circ_q3;     // fourth symmetric point selected
      logic   circ_end;    // y went below zero
      logic   read_ok;
   } sts_type;

endpackage

/* hdl/lcfr_if.sv */
// ----------------------------------------------------------------------------
// lcfr_req_if / lcfr_rsp_if / lcfr_csr_if
// Valid/ready channels of the rasterizer.
// ----------------------------------------------------------------------------
interface lcfr_req_if;
   logic                         valid;
   logic                         ready;
   lcfr_pkg::op_type             op;
   logic [lcfr_pkg::COORD_W-1:0] x_a;
   logic [lcfr_pkg::COORD_W-1:0] y_a;
   logic [lcfr_pkg::COORD_W-1:0] x_b;
   logic [lcfr_pkg::COORD_W-1:0] y_b;
   logic [lcfr_pkg::RAD_W-1:0]   radius;
   logic [lcfr_pkg::COLOR_W-1:0] color;
   modport source (output valid, op, x_a, y_a, x_b, y_b, radius, color, input ready);
   modport sink   (input valid, op, x_a, y_a, x_b, y_b, radius, color, output ready);
endinterface

interface lcfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic [lcfr_pkg::COLOR_W-1:0] pixel;
   modport source (output valid, status, pixel, input ready);
   modport sink   (input valid, status, pixel, output ready);
endinterface

interface lcfr_csr_if;
   logic                         valid;
   logic                         ready;
   logic                         index;
   logic [lcfr_pkg::COORD_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/lcfr_ram.sv */
// ----------------------------------------------------------------------------
// lcfr_ram
// Single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcfr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 57600
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/lcfr_datapath.sv */
// ----------------------------------------------------------------------------
// lcfr_datapath
// Coordinate registers, Bresenham and midpoint circle arithmetic, address
// generation and the frame store.
// ----------------------------------------------------------------------------
module lcfr_datapath #(
   parameter int MAX_WIDTH  = 240,
   parameter int MAX_HEIGHT = 240
) (
   input  logic                         clock,
   input  logic [lcfr_pkg::COORD_W-1:0] wid,
   input  logic [lcfr_pkg::COORD_W-1:0] hgt,
   input  lcfr_pkg::op_type             req_op,
   input  logic [lcfr_pkg::COORD_W-1:0] req_x_a,
   input  logic [lcfr_pkg::COORD_W-1:0] req_y_a,
   input  logic [lcfr_pkg::COORD_W-1:0] req_x_b,
   input  logic [lcfr_pkg::COORD_W-1:0] req_y_b,
   input  logic [lcfr_pkg::RAD_W-1:0]   req_radius,
   input  logic [lcfr_pkg::COLOR_W-1:0] req_color,
   input  lcfr_pkg::cmd_type            cmd,
   output lcfr_pkg::sts_type            sts,
   output logic                         rsp_status_o,
   output logic [lcfr_pkg::COLOR_W-1:0] rsp_pixel_o
);
   import lcfr_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = $clog2(DEPTH);
   localparam int CW     = COORD_W;
   localparam int EW     = CW + 3;   // signed error terms

   // Effective width and height, clipped to the store size.
   logic [CW:0] w_eff, h_eff;
   always_comb begin
      w_eff = (int'(wid) > MAX_WIDTH)  ? (CW+1)'(MAX_WIDTH)  : {1'b0, wid};
      h_eff = (int'(hgt) > MAX_HEIGHT) ? (CW+1)'(MAX_HEIGHT) : {1'b0, hgt};
   end

   op_type             op_ff;
   logic [CW-1:0]      xa_ff, ya_ff, xb_ff, yb_ff;
   logic [COLOR_W-1:0] color_ff;
   logic               reject_ff;
   logic [COLOR_W-1:0] pixel_ff;

   // Fill sweep.
   logic [AW:0] fill_addr_ff, fill_cnt_ff;
   logic [AW:0] fill_total_ff;

   // Span / Bresenham current point, both span walk counters.
   logic [CW-1:0]        cx_ff, cy_ff;
   logic [CW-1:0]        span_hi_ff;
   logic [CW-1:0]        dx_ff, dy_ff;
   logic                 sxn_ff, syn_ff;
   logic signed [EW-1:0] err_ff;

   // Circle state.
   logic [CW-1:0]        ox_ff;
   logic signed [CW:0]   oy_ff;
   logic signed [EW+1:0] delta_ff;
   logic [1:0]           q_ff;
   logic                 circ_ok_ff;

   // Pixel address: y * w_eff + x, registered.
   logic [AW-1:0] addr_ff;
   logic [CW-1:0] px, py;

   logic [COLOR_W-1:0] rd_q;
   logic [AW-1:0]      wa;

   // Input bounds check helper.
   function automatic logic inb(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                input logic [CW:0] w, input logic [CW:0] h);
      inb = ({1'b0, x} < w) && ({1'b0, y} < h);
   endfunction

   // Circle point for quadrant q.
   logic [CW-1:0] cpx, cpy;
   always_comb begin
      cpx = q_ff[1] ? xa_ff - ox_ff : xa_ff + ox_ff;
      cpy = q_ff[0] ? ya_ff - oy_ff[CW-1:0] : ya_ff + oy_ff[CW-1:0];
   end

   // Current drawn point per write select.
   always_comb begin
      unique case (cmd.wsel)
         2'd2:    begin px = xb_ff; py = yb_ff; end
         2'd3:    begin px = cpx;   py = cpy;   end
         default: begin px = cx_ff; py = cy_ff; end
      endcase
   end

   // Bresenham step values.
   logic signed [EW-1:0] e2, sdx, sdy, err_nx;
   logic [CW-1:0]        nx, ny;
   logic                 stepx, stepy;
   always_comb begin
      sdx    = EW'(dx_ff);
      sdy    = EW'(dy_ff);
      e2     = err_ff <<< 1;
      stepx  = e2 > -sdy;
      stepy  = e2 < sdx;
      err_nx = err_ff - (stepx ? sdy : EW'(0)) + (stepy ? sdx : EW'(0));
      nx     = stepx ? (sxn_ff ? cx_ff - 1'b1 : cx_ff + 1'b1) : cx_ff;
      ny     = stepy ? (syn_ff ? cy_ff - 1'b1 : cy_ff + 1'b1) : cy_ff;
   end

   // Midpoint circle step.
   logic signed [EW+1:0] sox, soy, c_e1, c_e2, d_nx;
   logic [CW-1:0]        ox_nx;
   logic signed [CW:0]   oy_nx;
   always_comb begin
      sox   = (EW+2)'(ox_ff);
      soy   = (EW+2)'(oy_ff);
      c_e1  = ((delta_ff + soy) <<< 1) - 1;
      c_e2  = ((delta_ff - sox) <<< 1) - 1;
      ox_nx = ox_ff;
      oy_nx = oy_ff;
      d_nx  = delta_ff;
      if (delta_ff < 0 && c_e1 <= 0) begin
         ox_nx = ox_ff + 1'b1;
         d_nx  = delta_ff + ((sox + 1) <<< 1) + 1;
      end else if (delta_ff > 0 && c_e2 > 0) begin
         oy_nx = oy_ff - 1'b1;
         d_nx  = delta_ff + 1 - ((soy - 1) <<< 1);
      end else begin
         ox_nx = ox_ff + 1'b1;
         oy_nx = oy_ff - 1'b1;
         d_nx  = delta_ff + (((sox + 1) - (soy - 1)) <<< 1);
      end
   end

   // Address: registered y*w + x (one multiply, then register).
   logic [AW-1:0] addr_nx;
   assign addr_nx = AW'(AW'(py) * AW'(w_eff)) + AW'(px);

   always_ff @(posedge clock) begin
      addr_ff    <= addr_nx;
      circ_ok_ff <= inb(cpx, cpy, w_eff, h_eff);
      if (cmd.load) begin
         op_ff     <= req_op;
         xa_ff     <= req_x_a;
         ya_ff     <= req_y_a;
         xb_ff     <= req_x_b;
         yb_ff     <= req_y_b;
         color_ff  <= req_color;
         reject_ff <= 1'b0;
         pixel_ff  <= '0;
         ox_ff     <= '0;
         oy_ff     <= (CW+1)'(req_radius);
         delta_ff  <= (EW+2)'(1) - ((EW+2)'(req_radius) <<< 1);
         // read address comes from the current point
         cx_ff     <= req_x_a;
         cy_ff     <= req_y_a;
      end
      if (cmd.set_reject) reject_ff <= 1'b1;
      if (cmd.take_pixel) pixel_ff <= rd_q;
      if (cmd.fill_init) begin
         fill_addr_ff  <= '0;
         fill_cnt_ff   <= '0;
         fill_total_ff <= (AW+1)'((AW+1)'(w_eff) * (AW+1)'(h_eff));
      end
      if (cmd.fill_step) begin
         fill_addr_ff <= fill_addr_ff + 1'b1;
         fill_cnt_ff  <= fill_cnt_ff + 1'b1;
      end
      if (cmd.span_init) begin
         if (ya_ff == yb_ff) begin
            cx_ff      <= (xa_ff < xb_ff) ? xa_ff : xb_ff;
            cy_ff      <= ya_ff;
            span_hi_ff <= (xa_ff < xb_ff) ? xb_ff : xa_ff;
         end else begin
            cx_ff      <= xa_ff;
            cy_ff      <= (ya_ff < yb_ff) ? ya_ff : yb_ff;
            span_hi_ff <= (ya_ff < yb_ff) ? yb_ff : ya_ff;
         end
      end
      if (cmd.span_step) begin
         if (ya_ff == yb_ff) cx_ff <= cx_ff + 1'b1;
         else                cy_ff <= cy_ff + 1'b1;
      end
      if (cmd.bres_init) begin
         cx_ff  <= xa_ff;
         cy_ff  <= ya_ff;
         dx_ff  <= (xb_ff > xa_ff) ? xb_ff - xa_ff : xa_ff - xb_ff;
         dy_ff  <= (yb_ff > ya_ff) ? yb_ff - ya_ff : ya_ff - yb_ff;
         sxn_ff <= !(xa_ff < xb_ff);
         syn_ff <= !(ya_ff < yb_ff);
         err_ff <= EW'((xb_ff > xa_ff) ? xb_ff - xa_ff : xa_ff - xb_ff)
                 - EW'((yb_ff > ya_ff) ? yb_ff - ya_ff : ya_ff - yb_ff);
      end
      if (cmd.bres_step) begin
         cx_ff  <= nx;
         cy_ff  <= ny;
         err_ff <= err_nx;
      end
      if (cmd.circ_init) q_ff <= '0;
      if (cmd.circ_next) q_ff <= q_ff + 1'b1;
      if (cmd.circ_step) begin
         ox_ff    <= ox_nx;
         oy_ff    <= oy_nx;
         delta_ff <= d_nx;
         q_ff     <= '0;
      end
   end

   assign wa = (cmd.wsel == 2'd0) ? fill_addr_ff[AW-1:0] : addr_ff;

   lcfr_ram #(.WIDTH(COLOR_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr),
      .wr_addr (wa),
      .wr_data (color_ff),
      .rd_en   (cmd.rd),
      .rd_addr (addr_ff),
      .rd_data (rd_q)
   );

   always_comb begin
      sts.op         = op_ff;
      sts.fill_empty = (fill_total_ff == '0);
      sts.fill_last  = (fill_cnt_ff == fill_total_ff - 1'b1);
      sts.ends_ok    = inb(xa_ff, ya_ff, w_eff, h_eff) && inb(xb_ff, yb_ff, w_eff, h_eff);
      sts.horiz      = (ya_ff == yb_ff);
      sts.vert       = (xa_ff == xb_ff);
      sts.span_last  = (ya_ff == yb_ff) ? (cx_ff == span_hi_ff) : (cy_ff == span_hi_ff);
      sts.bres_done  = (cx_ff == xb_ff) && (cy_ff == yb_ff);
      sts.bres_out   = !inb(cx_ff, cy_ff, w_eff, h_eff);
      sts.circ_ok    = circ_ok_ff;
      sts.circ_q3    = (q_ff == 2'd3);
      sts.circ_end   = oy_ff[CW];
      sts.read_ok    = inb(xa_ff, ya_ff, w_eff, h_eff);
   end

   assign rsp_status_o = reject_ff;
   assign rsp_pixel_o  = pixel_ff;
endmodule

/* hdl/lcfr_ctrl.sv */
// ----------------------------------------------------------------------------
// lcfr_ctrl
// Command sequencer: steps fill, span, Bresenham, circle and read walks.
// ----------------------------------------------------------------------------
module lcfr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               rsp_ready,
   input  lcfr_pkg::sts_type  sts,
   output lcfr_pkg::cmd_type  cmd,
   output logic               req_ready,
   output logic               rsp_valid
);
   import lcfr_pkg::*;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;  // address register settled

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   // Point states compute the address first, then write.
   always_comb begin
      state_in  = state_ff;
      pend_in   = 1'b0;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_LINE_CHK;
            end
         end
         ST_LINE_CHK: begin
            unique case (sts.op)
               OP_FILL: begin
                  cmd.fill_init = 1'b1;
                  state_in      = ST_FILL;
               end
               OP_LINE: begin
                  if (!sts.ends_ok) begin
                     cmd.set_reject = 1'b1;
                     state_in       = ST_DONE;
                  end else if (sts.horiz || sts.vert) begin
                     cmd.span_init = 1'b1;
                     state_in      = ST_HSPAN;
                  end else begin
                     cmd.bres_init = 1'b1;
                     state_in      = ST_BRES_END;
                  end
               end
               OP_CIRCLE: begin
                  cmd.circ_init = 1'b1;
                  state_in      = ST_CIRC_PT;
               end
               default: state_in = ST_READ_ADDR;
            endcase
         end
         ST_FILL: begin
            cmd.wsel = 2'd0;
            if (sts.fill_empty) begin
               state_in = ST_DONE;
            end else begin
               cmd.wr        = 1'b1;
               cmd.fill_step = 1'b1;
               if (sts.fill_last) state_in = ST_DONE;
            end
         end
         ST_HSPAN: begin
            cmd.wsel = 2'd1;
            if (!pend_ff) begin
               pend_in = 1'b1;
            end else begin
               cmd.wr = 1'b1;
               if (sts.span_last) state_in = ST_DONE;
               else               cmd.span_step = 1'b1;
            end
         end
         ST_BRES_END: begin
            cmd.wsel = 2'd2;
            if (!pend_ff) pend_in = 1'b1;
            else begin
               cmd.wr   = 1'b1;
               state_in = ST_BRES;
            end
         end
         ST_BRES: begin
            cmd.wsel = 2'd1;
            if (sts.bres_done) begin
               state_in = ST_DONE;
            end else if (!pend_ff) begin
               pend_in = 1'b1;
            end else begin
               cmd.wr        = 1'b1;
               cmd.bres_step = 1'b1;
               state_in      = ST_VSPAN;
            end
         end
         ST_VSPAN: begin
            // check the stepped point before plotting it
            cmd.wsel = 2'd1;
            state_in = sts.bres_out ? ST_DONE : ST_BRES;
         end
         ST_CIRC_PT: begin
            cmd.wsel = 2'd3;
            if (sts.circ_end) begin
               state_in = ST_DONE;
            end else if (!pend_ff) begin
               pend_in = 1'b1;
            end else if (!sts.circ_ok) begin
               state_in = ST_DONE;
            end else begin
               cmd.wr = 1'b1;
               if (sts.circ_q3) state_in = ST_CIRC_STEP;
               else             cmd.circ_next = 1'b1;
            end
         end
         ST_CIRC_STEP: begin
            cmd.wsel      = 2'd3;
            cmd.circ_step = 1'b1;
            state_in      = ST_CIRC_PT;
         end
         ST_READ_ADDR: begin
            cmd.wsel = 2'd1;
            state_in = sts.read_ok ? ST_READ_WAIT : ST_DONE;
         end
         ST_READ_WAIT: begin
            cmd.rd   = 1'b1;
            state_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            cmd.take_pixel = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Assertions: no write while idle, a response only in the done state, and each read followed by a pixel capture.
   property p_no_write_idle;
      @(posedge clock) disable iff (reset) (state_ff == ST_IDLE) |-> !cmd.wr;
   endproperty
   a_no_write_idle: assert property (p_no_write_idle) else $error("write while idle");

   a_rsp_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_DONE)) else $error("response outside done");

   a_read_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> cmd.take_pixel) else $error("read data not captured");
endmodule

/* hdl/line_circle_framebuffer_raster_top.sv */
// Sequencing: each span and circle point computes its address, then writes;
// each Bresenham point also checks the stepped point before it is plotted.
// Throughput: one command at a time; a new request is taken only when idle.
// Reset: synchronous, active high; returns to idle, width and height 240.
// Frame store contents are not cleared by reset.
// ----------------------------------------------------------------------------
// line_circle_framebuffer_raster_top
// RGB565 frame store with fill, line, circle and pixel read commands.
// ----------------------------------------------------------------------------
module line_circle_framebuffer_raster_top #(
   parameter int MAX_WIDTH  = 240,
   parameter int MAX_HEIGHT = 240
) (
   input  logic       clock,
   input  logic       reset,
   lcfr_req_if.sink   req,
   lcfr_rsp_if.source rsp,
   lcfr_csr_if.sink   csr
);
   import lcfr_pkg::*;

   logic [COORD_W-1:0] wid_ff, hgt_ff;
   cmd_type            cmd;
   sts_type            sts;
   logic               req_fire;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff <= COORD_W'(240);
         hgt_ff <= COORD_W'(240);
      end else if (csr.valid) begin
         if (csr.index == CSR_WIDTH) wid_ff <= csr.data;
         else                        hgt_ff <= csr.data;
      end
   end

   assign req_fire = req.valid && req.ready;

   lcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid)
   );

   lcfr_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock        (clock),
      .wid          (wid_ff),
      .hgt          (hgt_ff),
      .req_op       (req.op),
      .req_x_a      (req.x_a),
      .req_y_a      (req.y_a),
      .req_x_b      (req.x_b),
      .req_y_b      (req.y_b),
      .req_radius   (req.radius),
      .req_color    (req.color),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_status_o (rsp.status),
      .rsp_pixel_o  (rsp.pixel)
   );
endmodule
